// ===== design/cbc_pkg.sv =====
// shared constants and types for the colour blob centroid block
package cbc_pkg;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RUN    = 5;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd7;
  localparam int CFG_DATA_W = 11;

  localparam int TOTAL_W = 21;
  localparam int SUM_W   = 30;
  localparam int CENT_W  = 18;
  localparam int DIV_W   = SUM_W + 8;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [CENT_W-1:0]  centroid_col;
    logic [CENT_W-1:0]  centroid_row;
    logic [TOTAL_W-1:0] pixel_total;
    logic               found_none;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_req_t;

  // frame-end request to the divider
  typedef struct packed {
    logic [SUM_W-1:0]   col_sum;
    logic [SUM_W-1:0]   row_sum;
    logic [TOTAL_W-1:0] total;
  } div_req_t;
endpackage

// ===== design/cbc_if.sv =====
// valid/ready channel interfaces
interface cbc_pix_if;
  import cbc_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbc_res_if;
  import cbc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbc_cfg_if;
  import cbc_pkg::*;
  logic     valid;
  logic     ready;
  cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/cbc_divider.sv =====
// restoring divider producing both centroids, one quotient bit per cycle
module cbc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cbc_pkg::div_req_t req,
  output logic              busy,
  output logic              done,
  output cbc_pkg::result_t  res
);
  import cbc_pkg::*;
  localparam int CNT_W = $clog2(DIV_W + 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_W-1:0]   qc_r, qc_nxt, qr_r, qr_nxt;
  logic [TOTAL_W:0]   rc_r, rc_nxt, rr_r, rr_nxt;
  logic [TOTAL_W-1:0] d_r, d_nxt;
  logic [TOTAL_W:0]   tc, tr;

  // done stays high from completion until the next start
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    qc_nxt = qc_r; qr_nxt = qr_r; rc_nxt = rc_r; rr_nxt = rr_r; d_nxt = d_r;
    tc = {rc_r[TOTAL_W-1:0], qc_r[DIV_W-1]};
    tr = {rr_r[TOTAL_W-1:0], qr_r[DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(DIV_W);
      qc_nxt   = {req.col_sum, 8'd0};
      qr_nxt   = {req.row_sum, 8'd0};
      rc_nxt   = '0;
      rr_nxt   = '0;
      d_nxt    = req.total;
    end else if (busy_r) begin
      if (tc >= {1'b0, d_r}) begin
        rc_nxt = tc - {1'b0, d_r};
        qc_nxt = {qc_r[DIV_W-2:0], 1'b1};
      end else begin
        rc_nxt = tc;
        qc_nxt = {qc_r[DIV_W-2:0], 1'b0};
      end
      if (tr >= {1'b0, d_r}) begin
        rr_nxt = tr - {1'b0, d_r};
        qr_nxt = {qr_r[DIV_W-2:0], 1'b1};
      end else begin
        rr_nxt = tr;
        qr_nxt = {qr_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    qc_r <= qc_nxt; qr_r <= qr_nxt; rc_r <= rc_nxt; rr_r <= rr_nxt; d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  always_comb begin
    res.centroid_col = qc_r[CENT_W-1:0];
    res.centroid_row = qr_r[CENT_W-1:0];
    res.pixel_total  = d_r;
    res.found_none   = 1'b0;
  end
endmodule

// ===== design/color_blob_centroid.sv =====
// top level of the colour blob centroid block
//
//  channel  dir  payload                                          handshake
//  in_      in   blue, green, red                                 valid/ready
//  out_     out  centroid_col, centroid_row, pixel_total, found_none valid/ready
//  cfg_     in   register index, write data                       valid/ready
//
// each pixel is a read of the column store, then a modify and write back
// the column store holds run length and pending bits, one entry a column;
// after reset a clearing pass over all MAX_WIDTH entries runs before pixels are taken
// at frame end the divider forms both centroids if any pixel counted, input stalls
// until the result has gone into the output register
// rst_n is synchronous and active low
module color_blob_centroid #(
  parameter int MAX_WIDTH  = cbc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RUN    = cbc_pkg::DEF_MAX_RUN
) (
  input  logic clk,
  input  logic rst_n,
  cbc_pix_if.sink   in_ch,
  cbc_res_if.source out_ch,
  cbc_cfg_if.sink   cfg_ch
);
  import cbc_pkg::*;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int RW   = $clog2(MAX_RUN + 1);
  localparam int ENTW = RW + MAX_RUN;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_WAIT  = 3'd4;

  // configuration registers
  logic [1:0]  prim_r;
  logic [7:0]  thr_r, sec_r, third_r;
  logic        single_r;
  logic [2:0]  nrun_r;
  logic [10:0] wid_r, hei_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_r <= 2'd0; thr_r <= 8'd100; sec_r <= 8'd150; third_r <= 8'd100;
      single_r <= 1'b1; nrun_r <= 3'd2; wid_r <= 11'd640; hei_r <= 11'd480;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_PRIMARY:  prim_r   <= cfg_ch.data.data[1:0];
        REG_HIGH_THR: thr_r    <= cfg_ch.data.data[7:0];
        REG_SECOND:   sec_r    <= cfg_ch.data.data[7:0];
        REG_THIRD:    third_r  <= cfg_ch.data.data[7:0];
        REG_SINGLE:   single_r <= cfg_ch.data.data[0];
        REG_MIN_RUN:  nrun_r   <= cfg_ch.data.data[2:0];
        REG_WIDTH:    wid_r    <= cfg_ch.data.data;
        REG_HEIGHT:   hei_r    <= cfg_ch.data.data;
        default: ;
      endcase
    end
  end

  // clamped sizes and run length
  logic [AW:0] w_eff;
  logic [HW:0] h_eff;
  logic [RW-1:0] n_eff;
  always_comb begin
    if (wid_r == 11'd0) w_eff = (AW+1)'(1);
    else if (32'(wid_r) > MAX_WIDTH) w_eff = (AW+1)'(MAX_WIDTH);
    else w_eff = (AW+1)'(wid_r);
    if (hei_r == 11'd0) h_eff = (HW+1)'(1);
    else if (32'(hei_r) > MAX_HEIGHT) h_eff = (HW+1)'(MAX_HEIGHT);
    else h_eff = (HW+1)'(hei_r);
    if (32'(nrun_r) > MAX_RUN) n_eff = RW'(MAX_RUN);
    else n_eff = RW'(nrun_r);
  end

  // colour match, registered with the pixel
  logic [7:0] ch [3];
  logic       m_c;
  logic [1:0] p, p1, p2;
  always_comb begin
    ch[0] = in_ch.data.blue; ch[1] = in_ch.data.green; ch[2] = in_ch.data.red;
    p  = (prim_r == 2'd3) ? 2'd2 : prim_r;
    p1 = (p == 2'd2) ? 2'd0 : p + 2'd1;
    p2 = (p1 == 2'd2) ? 2'd0 : p1 + 2'd1;
    if (single_r) m_c = ch[p] > thr_r && ch[p1] < sec_r && ch[p2] < third_r;
    else m_c = ch[2] > thr_r && ch[1] > thr_r && ch[0] < sec_r;
  end

  logic [2:0]   st_r;
  logic [AW:0]  col_r;
  logic [HW:0]  row_r;
  logic         m_r;
  logic [AW:0]  clr_r;
  logic [TOTAL_W-1:0] tot_r;
  logic [SUM_W-1:0]   csum_r, rsum_r;
  logic         ov_r;
  result_t      ores_r;

  // column store
  logic [ENTW-1:0] mem [MAX_WIDTH];
  logic [ENTW-1:0] rd_q;
  logic            we;
  logic [AW-1:0]   wa, ra;
  logic [ENTW-1:0] wd;

  logic [AW:0] col_c;
  logic [HW:0] row_c;
  always_comb begin
    col_c = (col_r >= w_eff) ? w_eff - (AW+1)'(1) : col_r;
    row_c = (row_r >= h_eff) ? h_eff - (HW+1)'(1) : row_r;
  end
  assign ra = col_c[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // modify step
  logic [RW-1:0]      run_v, run_new;
  logic [MAX_RUN-1:0] mask_v, mask_new, nmask;
  logic               cnt_v, pend_v, late_v, last_col, last_row;
  logic [HW:0]        late_row;
  logic [TOTAL_W-1:0] tot_n;
  logic [SUM_W-1:0]   cs_n, rs_n;
  always_comb begin
    run_v  = (row_c == '0) ? '0 : rd_q[ENTW-1:MAX_RUN];
    mask_v = (row_c == '0) ? '0 : rd_q[MAX_RUN-1:0];
    cnt_v = 1'b0; pend_v = 1'b0;
    if (n_eff == '0 || row_c <= (HW+1)'(n_eff) ||
        (row_c + (HW+1)'(n_eff)) >= h_eff) cnt_v = m_r;
    else if (m_r) begin
      if (run_v >= n_eff) cnt_v = 1'b1;
      else pend_v = 1'b1;
    end
    late_v = 1'b0;
    if (n_eff != '0) late_v = m_r && mask_v[n_eff - RW'(1)] &&
                              row_c >= (HW+1)'(n_eff);
    late_row = row_c - (HW+1)'(n_eff);
    nmask = '0;
    for (int k = 0; k < MAX_RUN; k++) nmask[k] = (k < 32'(n_eff));
    if (m_r && n_eff != '0)
      mask_new = {mask_v[MAX_RUN-2:0], pend_v} & nmask;
    else mask_new = '0;
    run_new = m_r ? ((run_v < RW'(MAX_RUN)) ? run_v + RW'(1) : RW'(MAX_RUN)) : '0;
    tot_n = tot_r + TOTAL_W'(late_v) + TOTAL_W'(cnt_v);
    cs_n = csum_r + (late_v ? SUM_W'(col_c) : '0) + (cnt_v ? SUM_W'(col_c) : '0);
    rs_n = rsum_r + (late_v ? SUM_W'(late_row) : '0) + (cnt_v ? SUM_W'(row_c) : '0);
    last_col = (col_c + (AW+1)'(1)) >= w_eff;
    last_row = (row_c + (HW+1)'(1)) >= h_eff;
  end

  always_comb begin
    if (st_r == ST_CLEAR) begin
      we = 1'b1; wa = clr_r[AW-1:0]; wd = '0;
    end else begin
      we = (st_r == ST_CALC); wa = col_c[AW-1:0]; wd = {run_new, mask_new};
    end
  end

  // divider
  logic     dv_start, dv_busy, dv_done;
  div_req_t dv_req;
  result_t  dv_res;
  assign dv_req = '{col_sum: csum_r, row_sum: rsum_r, total: tot_r};
  cbc_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .req(dv_req),
    .busy(dv_busy), .done(dv_done), .res(dv_res)
  );

  // result moves into the output register only once that register is empty or being read
  logic res_load;
  always_comb begin
    dv_start = (st_r == ST_DIV) && (tot_r != '0);
    res_load = (st_r == ST_WAIT) && (!ov_r || out_ch.ready) &&
               ((tot_r == '0) || (dv_done && !dv_busy));
  end

  assign in_ch.ready  = (st_r == ST_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = ores_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; clr_r <= '0; col_r <= '0; row_r <= '0;
      tot_r <= '0; csum_r <= '0; rsum_r <= '0; ov_r <= 1'b0; m_r <= 1'b0;
    end else begin
      if (res_load) ov_r <= 1'b1;
      else if (out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        ST_CLEAR: begin
          clr_r <= clr_r + (AW+1)'(1);
          if (clr_r == (AW+1)'(MAX_WIDTH - 1)) st_r <= ST_IDLE;
        end
        ST_IDLE: if (in_ch.valid) begin
          m_r  <= m_c;
          st_r <= ST_CALC;
        end
        ST_CALC: begin
          tot_r <= tot_n; csum_r <= cs_n; rsum_r <= rs_n;
          st_r <= ST_IDLE;
          if (last_col) begin
            col_r <= '0;
            if (last_row) begin
              row_r <= '0;
              st_r  <= ST_DIV;
            end else row_r <= row_c + (HW+1)'(1);
          end else begin
            col_r <= col_c + (AW+1)'(1);
            row_r <= row_c;
          end
        end
        ST_DIV: begin
          st_r <= ST_WAIT;
        end
        ST_WAIT: if (res_load) begin
          if (tot_r == '0)
            ores_r <= '{centroid_col: '0, centroid_row: '0, pixel_total: '0,
                        found_none: 1'b1};
          else ores_r <= dv_res;
          tot_r <= '0; csum_r <= '0; rsum_r <= '0;
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
